/* hw/rtl/ctdl_pkg.sv */
// Package: shared codes, characters and command structs for the character translator.
package ctdl_pkg;

  // Item operation codes
  localparam logic [1:0] OP_FIRST  = 2'd0;
  localparam logic [1:0] OP_SECOND = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  // Set selectors
  localparam logic SET_FIRST  = 1'b0;
  localparam logic SET_SECOND = 1'b1;

  // Spec characters
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic [7:0] RANGE_SPAN_MAX = 8'd63;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPEC,
    S_SEL,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    P_IDLE,
    P_SCAN,
    P_RANGE
  } parse_state_t;

  // Write-side command from the spec parser to the set store
  typedef struct packed {
    logic       open;     // empty the selected set
    logic       put;      // append data to the selected set
    logic       set_sel;
    logic [7:0] data;
  } set_cmd_t;

  // Lookup request from the sequencer to the set store
  typedef struct packed {
    logic       pos_rd;   // read the position table at key
    logic       sec_rd;   // read the second set at the matched position
    logic [7:0] key;
  } lookup_req_t;

  // Lookup response from the set store
  typedef struct packed {
    logic       found;
    logic       has_second;
    logic [7:0] repl;
  } lookup_rsp_t;

  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      CH_LOWER_N: r = CH_NEWLINE;
      CH_LOWER_T: r = CH_TAB;
      CH_LOWER_R: r = CH_CR;
      CH_DIGIT_0: r = CH_NUL;
      default:    r = b;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/ctdl_if.sv */
// Interfaces: item, result and configuration channels of the character translator.
interface ctdl_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] value;
  logic       spec_last;

  modport source (output valid, output operation, output value, output spec_last, input ready);
  modport sink   (input valid, input operation, input value, input spec_last, output ready);
endinterface

interface ctdl_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       matched;

  modport source (output valid, output out_byte, output matched, input ready);
  modport sink   (input valid, input out_byte, input matched, output ready);
endinterface

interface ctdl_cfg_if;
  logic valid;
  logic ready;
  logic delete_mode;

  modport source (output valid, output delete_mode, input ready);
  modport sink   (input valid, input delete_mode, output ready);
endinterface

/* hw/rtl/ctdl_spec_parser.sv */
// Spec parser: lookahead window, escapes and range expansion into set writes.
module ctdl_spec_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              set_sel,
  input  logic [7:0]        ch,
  input  logic              last,
  output logic              done,
  output ctdl_pkg::set_cmd_t cmd
);

  ctdl_pkg::parse_state_t state, state_next;

  logic [7:0] la0, la1;
  logic [1:0] la_cnt;
  logic [1:0] closed;
  logic [7:0] w0, w1, w2;
  logic [1:0] n, p;
  logic       k_r, last_r;
  logic [7:0] cur, rend;

  logic       opening;
  logic [1:0] eff_cnt;
  logic [1:0] left;
  logic [7:0] a, b, c;
  logic       fin, go_range;
  logic [1:0] step;
  logic       range_ok;

  always_comb begin
    opening = closed[set_sel];
    eff_cnt = opening ? 2'd0 : la_cnt;
    left    = n - p;
    a       = (p == 2'd0) ? w0 : ((p == 2'd1) ? w1 : w2);
    b       = (p == 2'd0) ? w1 : w2;
    c       = w2;
    range_ok = (c > a) && ((c - a) <= ctdl_pkg::RANGE_SPAN_MAX);

    state_next = state;
    cmd        = '0;
    cmd.set_sel = k_r;
    done       = 1'b0;
    fin        = 1'b0;
    go_range   = 1'b0;
    step       = 2'd1;

    unique case (state)
      ctdl_pkg::P_IDLE: begin
        if (start) begin
          cmd.open    = opening;
          cmd.set_sel = set_sel;
          state_next  = ctdl_pkg::P_SCAN;
        end
      end
      ctdl_pkg::P_SCAN: begin
        if (left == 2'd0) begin
          fin = 1'b1;
        end else if (a == ctdl_pkg::CH_BSLASH) begin
          if (left >= 2'd2) begin
            cmd.put  = 1'b1;
            cmd.data = ctdl_pkg::escape_map(b);
            step     = 2'd2;
          end else if (!last_r) begin
            fin = 1'b1;
          end else begin
            cmd.put  = 1'b1;
            cmd.data = a;
          end
        end else if (left == 2'd1) begin
          if (!last_r) begin
            fin = 1'b1;
          end else begin
            cmd.put  = 1'b1;
            cmd.data = a;
          end
        end else if (b == ctdl_pkg::CH_DASH && left == 2'd2 && !last_r) begin
          fin = 1'b1;
        end else if (b == ctdl_pkg::CH_DASH && left == 2'd3 && range_ok) begin
          cmd.put  = 1'b1;
          cmd.data = a;
          step     = 2'd3;
          go_range = 1'b1;
        end else begin
          cmd.put  = 1'b1;
          cmd.data = a;
        end
        if (fin) begin
          done       = 1'b1;
          state_next = ctdl_pkg::P_IDLE;
        end else if (go_range) begin
          state_next = ctdl_pkg::P_RANGE;
        end
      end
      ctdl_pkg::P_RANGE: begin
        cmd.put  = 1'b1;
        cmd.data = cur;
        if (cur == rend) begin
          state_next = ctdl_pkg::P_SCAN;
        end
      end
      default: begin
        state_next = ctdl_pkg::P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ctdl_pkg::P_IDLE;
      la_cnt <= 2'd0;
      closed <= 2'b11;
    end else begin
      state <= state_next;
      if (state == ctdl_pkg::P_IDLE && start) begin
        if (opening) begin
          closed[set_sel]  <= 1'b0;
          closed[~set_sel] <= 1'b1;
        end
      end
      if (state == ctdl_pkg::P_SCAN && fin) begin
        la_cnt <= last_r ? 2'd0 : left;
        if (last_r) begin
          closed[k_r] <= 1'b1;
        end
      end
    end
  end

  // Window and lookahead payload
  always_ff @(posedge clk) begin
    if (state == ctdl_pkg::P_IDLE && start) begin
      w0     <= (eff_cnt != 2'd0) ? la0 : ch;
      w1     <= (eff_cnt == 2'd2) ? la1 : ((eff_cnt == 2'd1) ? ch : ctdl_pkg::CH_NUL);
      w2     <= (eff_cnt == 2'd2) ? ch : ctdl_pkg::CH_NUL;
      n      <= eff_cnt + 2'd1;
      p      <= 2'd0;
      k_r    <= set_sel;
      last_r <= last;
    end
    if (state == ctdl_pkg::P_SCAN) begin
      if (fin) begin
        la0 <= a;
        la1 <= b;
      end else begin
        p <= p + step;
      end
      if (go_range) begin
        cur  <= a + 8'd1;
        rend <= c;
      end
    end
    if (state == ctdl_pkg::P_RANGE) begin
      cur <= cur + 8'd1;
    end
  end

endmodule

/* hw/rtl/ctdl_set_store.sv */
// Set store: byte-to-position table for the first set and the second set memory.
module ctdl_set_store #(
  parameter int SET_CAPACITY = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctdl_pkg::set_cmd_t     cmd,
  input  ctdl_pkg::lookup_req_t  req,
  output ctdl_pkg::lookup_rsp_t  rsp
);

  localparam int LW = $clog2(SET_CAPACITY + 1);
  localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

  logic [LW-1:0] len0, len1;
  logic [255:0]  pos_valid;

  logic [IW-1:0] pos_mem [256];
  logic [7:0]    sec_mem [SET_CAPACITY];

  logic [IW-1:0] pos_q;
  logic          found_q;
  logic [7:0]    sec_q;

  logic          put0, put1;
  logic [LW-1:0] pos_ext, sel_full;

  always_comb begin
    put0     = cmd.put && cmd.set_sel == ctdl_pkg::SET_FIRST && len0 < LW'(SET_CAPACITY);
    put1     = cmd.put && cmd.set_sel == ctdl_pkg::SET_SECOND && len1 < LW'(SET_CAPACITY);
    pos_ext  = LW'(pos_q);
    sel_full = (pos_ext < len1) ? pos_ext : (len1 - LW'(1));
  end

  // Lengths and table valid bits; opening the first set drops every entry
  always_ff @(posedge clk) begin
    if (rst) begin
      len0      <= '0;
      len1      <= '0;
      pos_valid <= '0;
    end else begin
      if (cmd.open) begin
        if (cmd.set_sel == ctdl_pkg::SET_FIRST) begin
          len0      <= '0;
          pos_valid <= '0;
        end else begin
          len1 <= '0;
        end
      end
      if (put0) begin
        len0 <= len0 + LW'(1);
        pos_valid[cmd.data] <= 1'b1;
      end
      if (put1) begin
        len1 <= len1 + LW'(1);
      end
    end
  end

  // Keep only the first position of each byte
  always_ff @(posedge clk) begin
    if (put0 && !pos_valid[cmd.data]) begin
      pos_mem[cmd.data] <= len0[IW-1:0];
    end
    if (req.pos_rd) begin
      pos_q   <= pos_mem[req.key];
      found_q <= pos_valid[req.key];
    end
  end

  always_ff @(posedge clk) begin
    if (put1) begin
      sec_mem[len1[IW-1:0]] <= cmd.data;
    end
    if (req.sec_rd) begin
      sec_q <= sec_mem[sel_full[IW-1:0]];
    end
  end

  assign rsp.found      = found_q;
  assign rsp.has_second = (len1 != '0);
  assign rsp.repl       = sec_q;

endmodule

/* hw/rtl/char_translate_delete_stream.sv */
// Top level: tr-style byte translator and deleter with streaming set-spec parsing.
// Data byte: after acceptance come the table read, the second-set read and the output load
//   into the result register, in that order; the next transaction is taken once the sequencer is idle.
// A result still waiting at output load holds the data transaction until that result drains.
// Spec char: the sequencer waits while the parser emits each byte, every byte of a range included.
// Reset (rst, synchronous): both sets empty and closed, no lookahead, delete_mode 0.
module char_translate_delete_stream #(
  parameter int SET_CAPACITY = 63
) (
  input  logic               clk,
  input  logic               rst,
  ctdl_item_if.sink          item,
  ctdl_result_if.source      result,
  ctdl_cfg_if.sink           cfg
);

  ctdl_pkg::seq_state_t  state, state_next;
  ctdl_pkg::set_cmd_t    cmd;
  ctdl_pkg::lookup_req_t req;
  ctdl_pkg::lookup_rsp_t rsp;

  logic       delete_mode;
  logic       accept;
  logic       spec_start;
  logic       spec_done;
  logic [7:0] val_r;
  logic       out_load;
  logic       drop;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       matched;

  // Configuration: single register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delete_mode <= 1'b0;
    end else if (cfg.valid) begin
      delete_mode <= cfg.delete_mode;
    end
  end

  // Take a new transaction only when the sequencer is free; the result register
  // decouples the output side, so a waiting result blocks input only while the
  // next data result waits to load behind it.
  assign item.ready = (state == ctdl_pkg::S_IDLE);
  assign accept     = item.valid && item.ready;

  // Parser owns the lookahead and open/closed flags; it drives writes into the store.
  ctdl_spec_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .start   (spec_start),
    .set_sel (item.operation[0]),
    .ch      (item.value),
    .last    (item.spec_last),
    .done    (spec_done),
    .cmd     (cmd)
  );

  // Store keeps the byte-to-first-position table and the second set.
  ctdl_set_store #(
    .SET_CAPACITY (SET_CAPACITY)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  // A matched byte in delete mode produces no result.
  assign drop = rsp.found && delete_mode;

  // Sequencer: spec transactions wait for the parser; data transactions walk
  // through the two memory reads and then load the result register.
  always_comb begin
    state_next = state;
    spec_start = 1'b0;
    req        = '0;
    req.key    = item.value;
    out_load   = 1'b0;

    unique case (state)
      ctdl_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item.operation)
            ctdl_pkg::OP_FIRST, ctdl_pkg::OP_SECOND: begin
              spec_start = 1'b1;
              state_next = ctdl_pkg::S_SPEC;
            end
            ctdl_pkg::OP_DATA: begin
              req.pos_rd = 1'b1;
              state_next = ctdl_pkg::S_SEL;
            end
            default: begin
              // unused code: drop the transaction
              state_next = ctdl_pkg::S_IDLE;
            end
          endcase
        end
      end
      ctdl_pkg::S_SPEC: begin
        if (spec_done) begin
          state_next = ctdl_pkg::S_IDLE;
        end
      end
      ctdl_pkg::S_SEL: begin
        // position is in hand: read the replacement (clamped to the last entry)
        req.sec_rd = 1'b1;
        state_next = ctdl_pkg::S_OUT;
      end
      ctdl_pkg::S_OUT: begin
        if (drop) begin
          state_next = ctdl_pkg::S_IDLE;
        end else if (!out_valid || result.ready) begin
          // hold here while the result register is occupied and stalled
          out_load   = 1'b1;
          state_next = ctdl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ctdl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctdl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the data byte for the pass-through case
  always_ff @(posedge clk) begin
    if (accept && item.operation == ctdl_pkg::OP_DATA) begin
      val_r <= item.value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      // an empty second set leaves matched bytes unchanged
      out_byte <= (rsp.found && rsp.has_second) ? rsp.repl : val_r;
      matched  <= rsp.found;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.matched  = matched;

  // An accepted data transaction goes straight to the replacement read.
  a_data_to_sel: assert property (@(posedge clk) disable iff (rst)
    (accept && item.operation == ctdl_pkg::OP_DATA) |=> (state == ctdl_pkg::S_SEL))
    else $error("data transaction did not advance to the replacement read");

  // The parser finishes only while the sequencer waits for it.
  a_done_in_spec: assert property (@(posedge clk) disable iff (rst)
    spec_done |-> (state == ctdl_pkg::S_SPEC))
    else $error("parser finished outside a spec transaction");

  // Never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(result.valid && !result.ready))
    else $error("result register loaded while stalled");

  // No set writes while a data transaction reads the store.
  a_no_write_in_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == ctdl_pkg::S_SEL || state == ctdl_pkg::S_OUT) |-> !(cmd.put || cmd.open))
    else $error("set write during lookup");

endmodule

/* tb/ctdl_checker.sv */
// Checker: predicts translator results from observed transactions and compares them.
`timescale 1ns / 100ps
module ctdl_checker #(
  parameter int SET_CAPACITY = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_ready,
  input  logic [1:0] item_operation,
  input  logic [7:0] item_value,
  input  logic       item_spec_last,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic [7:0] result_out_byte,
  input  logic       result_matched,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_delete_mode,
  output int         pending_results,
  output int         mismatch_count
);

  localparam int RANGE_LIMIT = 63;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       matched;
  } tr_result_t;

  tr_result_t  expected_bytes [$];
  tr_result_t  want;
  logic [7:0]  set_bytes [2][SET_CAPACITY];
  int unsigned set_len [2];
  logic [7:0]  held_chars [2];
  int unsigned held_count;
  logic        escape_held;
  logic        spec_done [2];
  logic        drop_matched;
  int          error_total;

  task automatic clear_state();
    set_len[0]    = 0;
    set_len[1]    = 0;
    held_count    = 0;
    escape_held   = 1'b0;
    spec_done[0]  = 1'b1;
    spec_done[1]  = 1'b1;
    drop_matched  = 1'b0;
  endtask

  task automatic append_char(input logic k, input logic [7:0] b);
    if (set_len[k] < SET_CAPACITY) begin
      set_bytes[k][set_len[k]] = b;
      set_len[k]++;
    end
  endtask

  function automatic logic [7:0] escape_char(input logic [7:0] b);
    case (b)
      ctdl_pkg::CH_LOWER_N: return ctdl_pkg::CH_NEWLINE;
      ctdl_pkg::CH_LOWER_T: return ctdl_pkg::CH_TAB;
      ctdl_pkg::CH_LOWER_R: return ctdl_pkg::CH_CR;
      ctdl_pkg::CH_DIGIT_0: return ctdl_pkg::CH_NUL;
      default:              return b;
    endcase
  endfunction

  // Parse one spec character with up to two characters held from before.
  task automatic parse_spec_char(input logic k, input logic [7:0] x, input logic last);
    logic [7:0] w [3];
    int n;
    int p;
    int i;
    int v;
    int left;
    logic [7:0] a;
    logic [7:0] c;
    n = 0;
    p = 0;
    // opening a closed set empties it and closes the other spec
    if (spec_done[k]) begin
      spec_done[!k] = 1'b1;
      set_len[k]    = 0;
      held_count    = 0;
      escape_held   = 1'b0;
      spec_done[k]  = 1'b0;
    end
    if (escape_held) begin
      w[n] = ctdl_pkg::CH_BSLASH;
      n++;
    end
    for (i = 0; i < held_count && n < 2; i++) begin
      w[n] = held_chars[i];
      n++;
    end
    w[n] = x;
    n++;
    while (p < n) begin
      left = n - p;
      a    = w[p];
      if (a == ctdl_pkg::CH_BSLASH) begin
        if (left >= 2) begin
          append_char(k, escape_char(w[p+1]));
          p += 2;
        end else if (!last) begin
          break;
        end else begin
          append_char(k, a);
          p++;
        end
      end else if (left < 2 || (w[p+1] == ctdl_pkg::CH_DASH && left < 3)) begin
        if (!last) break;
        append_char(k, a);
        p++;
      end else if (w[p+1] == ctdl_pkg::CH_DASH && w[p+2] > a &&
                   int'(w[p+2]) - int'(a) <= RANGE_LIMIT) begin
        c = w[p+2];
        for (v = int'(a); v <= int'(c); v++) append_char(k, v[7:0]);
        p += 3;
      end else begin
        append_char(k, a);
        p++;
      end
    end
    escape_held = 1'b0;
    held_count  = 0;
    if (last) begin
      spec_done[k] = 1'b1;
    end else if (n - p == 1 && w[p] == ctdl_pkg::CH_BSLASH) begin
      escape_held = 1'b1;
    end else begin
      for (i = 0; p + i < n && i < 2; i++) held_chars[i] = w[p+i];
      held_count = i;
    end
  endtask

  // Look up a data byte; queue the outgoing byte unless delete mode drops it.
  task automatic translate_byte(input logic [7:0] v);
    tr_result_t  r;
    int unsigned j;
    int unsigned pos;
    logic        hit;
    hit = 1'b0;
    pos = 0;
    for (j = 0; j < set_len[ctdl_pkg::SET_FIRST]; j++) begin
      if (!hit && set_bytes[ctdl_pkg::SET_FIRST][j] == v) begin
        hit = 1'b1;
        pos = j;
      end
    end
    if (hit && drop_matched) return;
    r.out_byte = v;
    r.matched  = hit;
    if (hit && set_len[ctdl_pkg::SET_SECOND] > 0) begin
      r.out_byte = set_bytes[ctdl_pkg::SET_SECOND][(pos < set_len[ctdl_pkg::SET_SECOND]) ?
                                                   pos : set_len[ctdl_pkg::SET_SECOND] - 1];
    end
    expected_bytes.push_back(r);
  endtask

  initial begin
    error_total     = 0;
    pending_results = 0;
    mismatch_count  = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) drop_matched = cfg_delete_mode;
      if (item_valid && item_ready) begin
        case (item_operation)
          ctdl_pkg::OP_FIRST:  parse_spec_char(ctdl_pkg::SET_FIRST, item_value, item_spec_last);
          ctdl_pkg::OP_SECOND: parse_spec_char(ctdl_pkg::SET_SECOND, item_value,
                                               item_spec_last);
          ctdl_pkg::OP_DATA:   translate_byte(item_value);
          default:             ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result out_byte %02h matched %0b", $time,
                   result_out_byte, result_matched);
          error_total++;
        end else begin
          want = expected_bytes.pop_front();
          if (result_out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     want.out_byte, result_out_byte);
            error_total++;
          end
          if (result_matched !== want.matched) begin
            $display("%0t: matched expected %0b actual %0b", $time,
                     want.matched, result_matched);
            error_total++;
          end
        end
      end
    end
    pending_results <= expected_bytes.size();
    mismatch_count  <= error_total;
  end

endmodule

/* tb/testbench.sv */
// Testbench top: stimulus, flow control and verdict for the character translator.
`timescale 1ns / 100ps
module testbench;

  localparam int SET_CAPACITY = 63;
  // Code 3 is unused by the block; it must be swallowed without effect.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Drain margin, long enough for a spec char that expands a full range.
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 135;

  typedef struct {
    logic [7:0] lo;
    logic [7:0] hi;
  } char_span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic long_hold = 1'b0;
  int   pending_results;
  int   mismatch_count;

  // Recent spec characters and ranges; data bytes are drawn from them to hit the sets.
  char_span_t spec_spans [$];

  ctdl_item_if   item ();
  ctdl_result_if result ();
  ctdl_cfg_if    cfg ();

  char_translate_delete_stream #(
    .SET_CAPACITY(SET_CAPACITY)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  ctdl_checker #(
    .SET_CAPACITY(SET_CAPACITY)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_operation  (item.operation),
    .item_value      (item.value),
    .item_spec_last  (item.spec_last),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_out_byte (result.out_byte),
    .result_matched  (result.matched),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready),
    .cfg_delete_mode (cfg.delete_mode),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: drop ready at random, or for a long stretch while the hold is on.
  initial begin : result_sink
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst || long_hold) begin
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Long hold-off: count the cycles here so the sender keeps offering meanwhile.
  initial begin : hold_off
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Offer one item, with random idle cycles first; return at the accepting edge.
  // Leave valid high on return so back-to-back transactions need no second assignment.
  task automatic send_item(input logic [1:0] op, input logic [7:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid     <= 1'b1;
    item.operation <= op;
    item.value     <= v;
    item.spec_last <= last;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
  endtask

  task automatic write_delete_mode(input logic mode);
    cfg.valid       <= 1'b1;
    cfg.delete_mode <= mode;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Stop offering, wait for every expected result, then let spec expansion finish.
  task automatic drain();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_span(input logic [7:0] lo, input logic [7:0] hi);
    char_span_t s;
    s.lo = lo;
    s.hi = hi;
    spec_spans.push_back(s);
    if (spec_spans.size() > 16) void'(spec_spans.pop_front());
  endtask

  // Mostly bytes near recent spec content, the rest anywhere.
  function automatic logic [7:0] pick_data_byte();
    char_span_t s;
    if (spec_spans.size() != 0 && $urandom_range(99) < 65) begin
      s = spec_spans[$urandom_range(spec_spans.size() - 1)];
      return 8'($urandom_range(s.hi, s.lo));
    end
    return 8'($urandom_range(255));
  endfunction

  // Build a spec from random tokens (literals, escapes, ranges, dashes) and send it.
  // Now and then leave it open, or fill the set past capacity.
  task automatic send_spec(input logic [1:0] op, output int count);
    logic [7:0] chars [$];
    logic [7:0] b;
    int   ntok;
    int   span;
    int   lo;
    int   hi;
    logic fill;
    logic open;
    fill = ($urandom_range(11) == 0);
    open = ($urandom_range(9) == 0);
    ntok = fill ? 3 : $urandom_range(4, 1);
    repeat (ntok) begin
      case (fill ? 5 : $urandom_range(9))
        0, 1, 2, 9: begin
          b = 8'($urandom_range(255));
          chars.push_back(b);
          note_span(b, b);
        end
        3, 4: begin
          case ($urandom_range(5))
            0:       b = ctdl_pkg::CH_LOWER_N;
            1:       b = ctdl_pkg::CH_LOWER_T;
            2:       b = ctdl_pkg::CH_LOWER_R;
            3:       b = ctdl_pkg::CH_DIGIT_0;
            4:       b = ctdl_pkg::CH_BSLASH;
            default: b = 8'($urandom_range(255));
          endcase
          chars.push_back(ctdl_pkg::CH_BSLASH);
          chars.push_back(b);
        end
        5, 6, 7: begin
          // span 63 is the widest range, 64 is one too many, 0 is no range
          case (fill ? 0 : $urandom_range(9))
            0:       span = 63;
            1:       span = 64;
            2:       span = 0;
            default: span = $urandom_range(24, 1);
          endcase
          lo = $urandom_range(255 - span);
          hi = lo + span;
          note_span(lo[7:0], hi[7:0]);
          if ($urandom_range(7) == 0) begin
            chars.push_back(hi[7:0]);
            chars.push_back(ctdl_pkg::CH_DASH);
            chars.push_back(lo[7:0]);
          end else begin
            chars.push_back(lo[7:0]);
            chars.push_back(ctdl_pkg::CH_DASH);
            chars.push_back(hi[7:0]);
          end
        end
        default: begin
          chars.push_back(ctdl_pkg::CH_DASH);
          note_span(ctdl_pkg::CH_DASH, ctdl_pkg::CH_DASH);
        end
      endcase
    end
    // dangling backslash at the end
    if ($urandom_range(9) == 0) chars.push_back(ctdl_pkg::CH_BSLASH);
    foreach (chars[i]) send_item(op, chars[i], !open && i == chars.size() - 1);
    count = chars.size();
  endtask

  // One random phase: specs, bursts of data and a little noise.
  task automatic run_random(input int target, input logic with_hold);
    int sent;
    int got;
    int pick;
    sent = 0;
    while (sent < target) begin
      if (with_hold && !hold_req && sent >= target / 2) begin
        // Hold results off and keep feeding data so the block backs up.
        hold_req = 1'b1;
        repeat (24) send_item(ctdl_pkg::OP_DATA, pick_data_byte(), 1'($urandom_range(1)));
        sent += 24;
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 28) begin
        send_spec(($urandom_range(9) < 6) ? ctdl_pkg::OP_FIRST : ctdl_pkg::OP_SECOND, got);
        sent += got;
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_item(ctdl_pkg::OP_DATA, pick_data_byte(), 1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    item.valid      = 1'b0;
    item.operation  = ctdl_pkg::OP_DATA;
    item.value      = 8'h00;
    item.spec_last  = 1'b0;
    cfg.valid       = 1'b0;
    cfg.delete_mode = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_delete_mode(1'b0);

    // Empty first set: nothing matches. Unused code: no effect. Last mark on data: ignored.
    send_item(ctdl_pkg::OP_DATA, 8'hFF, 1'b0);
    send_item(OP_UNUSED, 8'h00, 1'b1);
    send_item(ctdl_pkg::OP_DATA, 8'h00, 1'b1);

    // First set "\t\\\qa-cz-": escapes, a range and a trailing "z-".
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_LOWER_T, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, "q", 1'b0);
    send_item(ctdl_pkg::OP_FIRST, "a", 1'b0);
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_DASH, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, "c", 1'b0);
    send_item(ctdl_pkg::OP_FIRST, "z", 1'b0);
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_DASH, 1'b1);
    // matched with an empty second set: pass unchanged
    send_item(ctdl_pkg::OP_DATA, "b", 1'b0);

    // Second set "12\" with a lone trailing backslash, shorter than the first.
    send_item(ctdl_pkg::OP_SECOND, "1", 1'b0);
    send_item(ctdl_pkg::OP_SECOND, "2", 1'b0);
    send_item(ctdl_pkg::OP_SECOND, ctdl_pkg::CH_BSLASH, 1'b1);
    send_item(ctdl_pkg::OP_DATA, ctdl_pkg::CH_TAB, 1'b0);
    send_item(ctdl_pkg::OP_DATA, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_DATA, "c", 1'b0);
    send_item(ctdl_pkg::OP_DATA, ctdl_pkg::CH_DASH, 1'b0);

    // Widest range 00-3F overflows the set; leave the spec open with "@" held,
    // look up during the open spec, then close it by opening the second set.
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_NUL, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, ctdl_pkg::CH_DASH, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, 8'h3F, 1'b0);
    send_item(ctdl_pkg::OP_FIRST, "@", 1'b0);
    send_item(ctdl_pkg::OP_DATA, 8'h3F, 1'b0);
    send_item(ctdl_pkg::OP_SECOND, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_SECOND, ctdl_pkg::CH_LOWER_N, 1'b0);
    send_item(ctdl_pkg::OP_SECOND, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_SECOND, ctdl_pkg::CH_DIGIT_0, 1'b0);
    send_item(ctdl_pkg::OP_SECOND, ctdl_pkg::CH_BSLASH, 1'b0);
    send_item(ctdl_pkg::OP_SECOND, ctdl_pkg::CH_LOWER_R, 1'b1);
    send_item(ctdl_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(ctdl_pkg::OP_DATA, "@", 1'b0);
    drain();

    // Delete mode: drop a matched byte, pass an unmatched one.
    write_delete_mode(1'b1);
    send_item(ctdl_pkg::OP_DATA, 8'h05, 1'b0);
    send_item(ctdl_pkg::OP_DATA, 8'hC8, 1'b0);
    drain();

    // Slow receiver, translating, with one long hold-off.
    send_idle_pct <= 7;
    recv_idle_pct <= 62;
    write_delete_mode(1'b0);
    run_random(PHASE_ITEMS, 1'b1);
    drain();

    // Slow sender, deleting.
    send_idle_pct <= 62;
    recv_idle_pct <= 7;
    write_delete_mode(1'b1);
    run_random(PHASE_ITEMS, 1'b0);
    drain();

    // Full rate on both sides, translating.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_delete_mode(1'b0);
    run_random(PHASE_ITEMS, 1'b0);
    drain();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
